// ===== rtl/char_stack_palindrome_check_macros.svh =====
// Assertion macros used by the character stack checker.
`ifndef CHAR_STACK_PALINDROME_CHECK_MACROS_SVH
`define CHAR_STACK_PALINDROME_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CSP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/csp_pkg.sv =====
// Package: sizes, action and status codes of the character stack.
`timescale 1ns / 1ps

package csp_pkg;

   // Stack geometry
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = 7;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // Item fields
   localparam int ACT_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 2;

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

   // Actions
   localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
   localparam logic [ACT_W-1:0] ACT_CHECK = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [CNT_W-1:0]  count_type;

endpackage

// ===== rtl/csp_if.sv =====
// Interfaces: request and response channels of the character stack.
`timescale 1ns / 1ps

interface csp_req_if
   import csp_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [ACT_W-1:0]    action;
   logic [CHAR_W-1:0]   ch;

   modport source (output valid, output action, output ch, input ready);
   modport sink   (input valid, input action, input ch, output ready);
endinterface

interface csp_rsp_if
   import csp_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                is_palindrome;
   logic [CNT_W-1:0]    entry_count;

   modport source (output valid, output status, output is_palindrome,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input is_palindrome,
                   input entry_count, output ready);
endinterface

// ===== rtl/char_stack_palindrome_check.sv =====
// Top level: bounded byte stack with a two-ended palindrome walk.
//
// req_bus carries one item per handshake: an action (push, pop, clear,
// check) and a character used by push. rsp_bus returns exactly one item per
// request: status, palindrome flag and the entry count after the action.
// Push, pop and clear complete at the accepting edge; their response is
// valid the next cycle. A check walks the stored characters from both ends,
// one step per cycle (one pair compared or one space skipped), using the two
// read ports of the character memory; its response is registered when the
// walk ends. No request is taken while a walk runs. The response sits in an
// output register; a new request is taken in the cycle the old one drains,
// so short actions sustain one item per cycle while responses drain without
// stall. A stalled response holds and blocks further requests. Synchronous
// reset empties the stack and drops any pending response; the memory needs
// no clearing since only entries below the count are ever read.
`timescale 1ns / 1ps

module char_stack_palindrome_check
   import csp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   csp_req_if.sink           req_bus,
   csp_rsp_if.source         rsp_bus
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WALK = 1'b1;

   logic                state_ff, state_in;
   count_type           count_ff, count_in;
   count_type           lo_ff, lo_in;
   count_type           hi_ff, hi_in;
   count_type           hi_dec;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                pal_ff, pal_in;
   count_type           rsp_count_ff, rsp_count_in;

   char_type            char_store [DEPTH];
   char_type            rd_lo_ff, rd_hi_ff;
   logic                wr_en;
   logic [ADDR_W-1:0]   rd_lo_addr, rd_hi_addr;

   logic                req_fire, rsp_take;

   // Handshake
   assign rsp_take      = rsp_valid_ff & rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE) & (~rsp_valid_ff | rsp_bus.ready);
   assign req_fire      = req_bus.valid & req_bus.ready;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = status_ff;
   assign rsp_bus.is_palindrome = pal_ff;
   assign rsp_bus.entry_count   = rsp_count_ff;

   // Action decode and walk step
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_take;
      status_in    = status_ff;
      pal_in       = pal_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               status_in = ST_OK;
               pal_in    = 1'b0;
               unique case (req_bus.action)
                  ACT_PUSH: begin
                     if (count_ff >= DEPTH_CNT) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_POP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ACT_CHECK: begin
                     lo_in    = '0;
                     hi_in    = count_ff;
                     state_in = S_WALK;
                  end
               endcase
               if (req_bus.action != ACT_CHECK) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = count_in;
               end
            end
         end
         S_WALK: begin
            // read data belongs to lo_ff and hi_ff - 1
            priority if (lo_ff >= hi_ff) begin
               pal_in   = 1'b1;
               state_in = S_IDLE;
            end else if (rd_lo_ff == SPACE_CHAR) begin
               lo_in = lo_ff + 1'b1;
            end else if (rd_hi_ff == SPACE_CHAR) begin
               hi_in = hi_ff - 1'b1;
            end else if (hi_ff - 1'b1 <= lo_ff) begin
               pal_in   = 1'b1;
               state_in = S_IDLE;
            end else if (rd_lo_ff != rd_hi_ff) begin
               pal_in   = 1'b0;
               state_in = S_IDLE;
            end else begin
               lo_in = lo_ff + 1'b1;
               hi_in = hi_ff - 1'b1;
            end
            if (state_in == S_IDLE) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               rsp_count_in = count_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Read addresses follow the next walk bounds
   assign hi_dec     = hi_in - 1'b1;
   assign rd_lo_addr = lo_in[ADDR_W-1:0];
   assign rd_hi_addr = hi_dec[ADDR_W-1:0];

   // Character memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         char_store[count_ff[ADDR_W-1:0]] <= req_bus.ch;
      end
      rd_lo_ff <= char_store[rd_lo_addr];
      rd_hi_ff <= char_store[rd_hi_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      status_ff    <= status_in;
      pal_ff       <= pal_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule

// ===== rtl/csp_checker.sv =====
// Checker: port-level assertions for the character stack, bound to the top.
`timescale 1ns / 1ps
`include "char_stack_palindrome_check_macros.svh"

module csp_checker
   import csp_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_is_palindrome,
   input logic [CNT_W-1:0]    rsp_entry_count
);

   // A stalled response stays up
   `CSP_ASSERT_NEXT(a_rsp_hold, clock, reset,
                    rsp_valid && !rsp_ready, rsp_valid,
                    "response dropped while stalled")

   // The count never passes the stack depth
   `CSP_ASSERT_NOW(a_count_bound, clock, reset,
                   rsp_valid, rsp_entry_count <= DEPTH_CNT,
                   "entry count above depth")

   // A refused push only happens on a full stack
   `CSP_ASSERT_NOW(a_full_count, clock, reset,
                   rsp_valid && rsp_status == ST_FULL, rsp_entry_count == DEPTH_CNT,
                   "full status with room left")

   // Palindrome flag comes only with an ok status
   `CSP_ASSERT_NOW(a_pal_ok, clock, reset,
                   rsp_valid && rsp_is_palindrome, rsp_status == ST_OK,
                   "palindrome flag with error status")

endmodule

bind char_stack_palindrome_check csp_checker u_csp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_is_palindrome (rsp_bus.is_palindrome),
   .rsp_entry_count   (rsp_bus.entry_count)
);

// ===== test/char_stack_palindrome_check_test.sv =====
// Testbench: self-checking random and directed test of the character stack palindrome checker.
`timescale 1ns / 1ps

module char_stack_palindrome_check_test;
   import csp_pkg::*;

   localparam int CLK_PERIOD    = 20;
   localparam int RESET_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 560;
   localparam int SETTLE_CYCLES = DEPTH + 8;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                is_palindrome;
      count_type           entry_count;
   } stack_result_type;

   typedef enum int {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_LONG} stall_mode_type;

   logic clock;
   logic reset;

   csp_req_if req_bus ();
   csp_rsp_if rsp_bus ();

   char_stack_palindrome_check u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predicted stack contents, bottom at index 0
   char_type         model_chars [DEPTH];
   int unsigned      model_count = 0;
   stack_result_type expected_results [$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned burst_left     = 0;
   int unsigned items_sent     = 0;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Non-space characters read the same from both ends
   function automatic logic stack_reads_palindrome();
      char_type letters [$];
      for (int i = 0; i < model_count; i++)
         if (model_chars[i] != SPACE_CHAR) letters.push_back(model_chars[i]);
      for (int i = 0; i < letters.size() / 2; i++)
         if (letters[i] != letters[letters.size() - 1 - i]) return 1'b0;
      return 1'b1;
   endfunction

   // Apply one accepted item to the predicted stack and return its response
   function automatic stack_result_type apply_stack_action(logic [ACT_W-1:0] action,
                                                           char_type ch);
      stack_result_type res;
      res.status        = ST_OK;
      res.is_palindrome = 1'b0;
      case (action)
         ACT_PUSH: begin
            if (model_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               model_chars[model_count] = ch;
               model_count++;
            end
         end
         ACT_POP: begin
            if (model_count == 0) res.status = ST_EMPTY;
            else model_count--;
         end
         ACT_CLEAR: begin
            model_count = 0;
         end
         default: begin
            res.is_palindrome = stack_reads_palindrome();
         end
      endcase
      res.entry_count = count_type'(model_count);
      return res;
   endfunction

   function automatic char_type random_letter();
      char_type c;
      do c = char_type'($urandom_range(0, 255)); while (c == SPACE_CHAR);
      return c;
   endfunction

   function automatic void note_mismatch(string what, stack_result_type want,
                                         stack_result_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s: want st %0d pal %0d cnt %0d, got st %0d pal %0d cnt %0d",
                  $time, what, want.status, want.is_palindrome, want.entry_count,
                  got.status, got.is_palindrome, got.entry_count);
   endfunction

   // Sender: bursts of random length separated by random gaps
   task automatic pause_sender(int unsigned cycles);
      if (cycles > 0) begin
         req_bus.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_item(logic [ACT_W-1:0] action, char_type ch);
      if (burst_left == 0) begin
         pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_bus.valid  <= 1'b1;
      req_bus.action <= action;
      req_bus.ch     <= ch;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      expected_results.push_back(apply_stack_action(action, ch));
   endtask

   // Hold off the sender until every pending response has been checked
   task automatic wait_for_responses();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // Receiver: ready follows a stall mode that is picked anew when its phase runs out
   initial begin
      stall_mode_type mode;
      int unsigned    phase;
      mode  = STALL_NONE;
      phase = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase == 0) begin
            mode  = stall_mode_type'($urandom_range(0, 3));
            phase = $urandom_range(16, 96);
         end
         phase--;
         case (mode)
            STALL_NONE:  rsp_bus.ready <= 1'b1;
            STALL_HALF:  rsp_bus.ready <= ($urandom_range(0, 1) == 0);
            STALL_LIGHT: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default:     rsp_bus.ready <= ((phase % 12) < 3);
         endcase
      end
   end

   // Response checker
   always @(posedge clock) begin
      stack_result_type got;
      stack_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status        = rsp_bus.status;
         got.is_palindrome = rsp_bus.is_palindrome;
         got.entry_count   = rsp_bus.entry_count;
         if (expected_results.size() == 0) begin
            note_mismatch("response with nothing pending", got, got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) note_mismatch("response differs", want, got);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("char_stack_palindrome_check_test NOT OK");
         $finish;
      end
   end

   // Pop, clear and check on an empty stack
   task automatic test_empty_stack();
      send_item(ACT_POP, 8'h00);
      send_item(ACT_CLEAR, 8'hFF);
      send_item(ACT_CHECK, 8'h00);
   endtask

   // Character extremes, spaces, single letters and mismatches
   task automatic test_edge_characters();
      send_item(ACT_PUSH, 8'h00);
      send_item(ACT_PUSH, 8'hFF);
      send_item(ACT_CHECK, 8'h00);
      send_item(ACT_POP, 8'h00);
      send_item(ACT_POP, 8'h00);
      send_item(ACT_POP, 8'h00);
      // only spaces held
      send_item(ACT_PUSH, SPACE_CHAR);
      send_item(ACT_CHECK, 8'h00);
      // one letter behind a space
      send_item(ACT_PUSH, 8'h61);
      send_item(ACT_CHECK, 8'h00);
      send_item(ACT_PUSH, SPACE_CHAR);
      send_item(ACT_PUSH, 8'h61);
      send_item(ACT_CHECK, 8'h00);
      send_item(ACT_PUSH, 8'h62);
      send_item(ACT_CHECK, 8'h00);
      send_item(ACT_CLEAR, 8'h00);
      send_item(ACT_CHECK, 8'h00);
   endtask

   // Fill to capacity, refused push, check at full depth
   task automatic test_full_stack();
      char_type half [DEPTH/2];
      foreach (half[i]) half[i] = random_letter();
      send_item(ACT_CLEAR, char_type'($urandom_range(0, 255)));
      for (int i = 0; i < DEPTH; i++)
         send_item(ACT_PUSH, (i < DEPTH/2) ? half[i] : half[DEPTH-1-i]);
      send_item(ACT_CHECK, 8'h00);
      send_item(ACT_PUSH, random_letter());
      send_item(ACT_POP, 8'hFF);
      send_item(ACT_CHECK, 8'h00);
      send_item(ACT_PUSH, half[0]);
      send_item(ACT_CHECK, 8'h00);
      send_item(ACT_CLEAR, 8'h00);
   endtask

   // Clear, push a palindrome (or a spoiled one) with spaces mixed in, check
   task automatic run_palindrome_sequence();
      char_type    letters [$];
      int unsigned letter_total;
      int unsigned room;
      int unsigned pos;
      char_type    old_char;
      send_item(ACT_CLEAR, char_type'($urandom_range(0, 255)));
      letter_total = ($urandom_range(0, 7) == 0) ? $urandom_range(0, DEPTH)
                                                 : $urandom_range(0, 12);
      for (int i = 0; i < letter_total; i++)
         letters.push_back((i < (letter_total + 1) / 2) ? random_letter()
                                                        : letters[letter_total - 1 - i]);
      // spoil one letter in the lower half
      if (letter_total >= 2 && $urandom_range(0, 2) == 0) begin
         pos      = $urandom_range(0, letter_total / 2 - 1);
         old_char = letters[pos];
         do letters[pos] = random_letter(); while (letters[pos] == old_char);
      end
      room = DEPTH - letter_total;
      foreach (letters[i]) begin
         if (room > 0 && $urandom_range(0, 4) == 0) begin
            send_item(ACT_PUSH, SPACE_CHAR);
            room--;
         end
         send_item(ACT_PUSH, letters[i]);
      end
      repeat ($urandom_range(0, 2)) begin
         if (room > 0) begin
            send_item(ACT_PUSH, SPACE_CHAR);
            room--;
         end
      end
      send_item(ACT_CHECK, char_type'($urandom_range(0, 255)));
      // trim the top and look again
      if ($urandom_range(0, 1) == 0) begin
         repeat ($urandom_range(1, 3)) send_item(ACT_POP, char_type'($urandom_range(0, 255)));
         send_item(ACT_CHECK, 8'h00);
      end
      // top up to capacity and push past it
      if ($urandom_range(0, 7) == 0) begin
         while (model_count < DEPTH) send_item(ACT_PUSH, random_letter());
         send_item(ACT_PUSH, char_type'($urandom_range(0, 255)));
         send_item(ACT_CHECK, 8'h00);
      end
   endtask

   // Unstructured actions with random characters
   task automatic run_random_actions();
      logic [ACT_W-1:0] action;
      repeat ($urandom_range(1, 8)) begin
         action = ACT_W'($urandom_range(0, 3));
         send_item(action, char_type'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random_sequences();
      int unsigned stop_at;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            7, 8:    run_random_actions();
            9:       begin
               run_random_actions();
               wait_for_responses();
            end
            default: run_palindrome_sequence();
         endcase
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.action <= ACT_PUSH;
      req_bus.ch     <= 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_empty_stack();
      test_edge_characters();
      wait_for_responses();
      test_full_stack();
      wait_for_responses();
      test_random_sequences();

      // drain and let any late response show up
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("char_stack_palindrome_check_test OK");
      end else begin
         $display("char_stack_palindrome_check_test NOT OK");
      end
      $finish;
   end

endmodule
